// File: src/dqd_pkg.sv
// Shared types and constants for the dual quadrature decoder.
// No dependencies; imported by dqd_step and dual_quadrature_decoder.
`default_nettype none

package dqd_pkg;

    localparam int OUT_WIDTH = 32;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_REBASE = 2'd2,
        CMD_SEED   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic load_phase;
        logic load_count;
        logic load_last;
    } step_ctl_t;

endpackage

`default_nettype wire

// File: src/dqd_step.sv
// Combinational update of one wheel's state for one command item.
// Depends on dqd_pkg for the command codes and the control struct.
`default_nettype none

module dqd_step #(
    parameter int COUNT_WIDTH = 32
) (
    input  dqd_pkg::cmd_t                   cmd,
    input  logic                            phase_a,
    input  logic                            phase_b,
    input  logic                            prev_a,
    input  logic                            prev_b,
    input  logic [COUNT_WIDTH-1:0]          count,
    input  logic [COUNT_WIDTH-1:0]          last,
    output logic [COUNT_WIDTH-1:0]          count_next,
    output logic [COUNT_WIDTH-1:0]          last_next,
    output logic signed [dqd_pkg::OUT_WIDTH-1:0] delta,
    output logic signed [dqd_pkg::OUT_WIDTH-1:0] position,
    output dqd_pkg::step_ctl_t              ctl
);
    import dqd_pkg::*;

    logic                   step_en;
    logic                   step_dn;
    logic [COUNT_WIDTH-1:0] stepped;
    logic [COUNT_WIDTH-1:0] diff;

    always_comb begin
        step_en = (phase_a != prev_a) || (phase_b != prev_b);
        if (phase_a != prev_a) begin
            step_dn = (phase_a != phase_b);
        end else begin
            step_dn = (phase_a == phase_b);
        end
        stepped = count + (step_dn ? {COUNT_WIDTH{1'b1}} : COUNT_WIDTH'(1));
        diff    = count - last;
    end

    always_comb begin
        count_next = count;
        last_next  = last;
        delta      = '0;
        ctl        = '0;
        unique case (cmd)
            CMD_SAMPLE: begin
                ctl.load_phase = 1'b1;
                ctl.load_count = 1'b1;
                if (step_en) begin
                    count_next = stepped;
                end
            end
            CMD_READ: begin
                ctl.load_last = 1'b1;
                last_next     = count;
                delta         = OUT_WIDTH'(signed'(diff));
            end
            CMD_REBASE: begin
                ctl.load_last = 1'b1;
                last_next     = count;
            end
            CMD_SEED: begin
                ctl.load_phase = 1'b1;
                ctl.load_count = 1'b1;
                ctl.load_last  = 1'b1;
                count_next     = '0;
                last_next      = '0;
            end
            default: begin
                count_next = count;
            end
        endcase
        position = OUT_WIDTH'(signed'(count_next));
    end

endmodule

`default_nettype wire

// File: src/dual_quadrature_decoder.sv
// Top level of the dual quadrature decoder: input register, per-wheel state, result register.
// Depends on dqd_pkg and dqd_step.
`default_nettype none

// x4 quadrature decoder keeping a signed position count per wheel. Each item is a
// command (sample phases, read delta, rebase read point, seed baseline) for one wheel
// and produces exactly one result with the count change (read only, else 0) and the
// wheel's position after the command. An item is registered on entry, processed by a
// single compare-and-increment stage against the wheel's state, and then lands in the result
// register. One item is taken every cycle while the result register is empty or being
// read. A result waiting on m_ready lets one more item into an empty input register but
// holds every later item back until it is taken. A wheel index at or above WHEELS
// changes nothing and returns zeros.
module dual_quadrature_decoder #(
    parameter int WHEELS      = 2,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  dqd_pkg::cmd_t                        s_command,
    input  logic                                 s_wheel,
    input  logic                                 s_phase_a,
    input  logic                                 s_phase_b,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [dqd_pkg::OUT_WIDTH-1:0] m_delta,
    output logic signed [dqd_pkg::OUT_WIDTH-1:0] m_position
);
    import dqd_pkg::*;

    localparam int WIDX = (WHEELS > 1) ? $clog2(WHEELS) : 1;

    logic                   in_valid_reg;
    cmd_t                   in_cmd_reg;
    logic                   in_wheel_reg;
    logic                   in_a_reg;
    logic                   in_b_reg;

    logic [WHEELS-1:0]      prev_a_reg;
    logic [WHEELS-1:0]      prev_b_reg;
    logic [COUNT_WIDTH-1:0] count_reg [WHEELS];
    logic [COUNT_WIDTH-1:0] last_reg  [WHEELS];

    logic                          m_valid_reg;
    logic signed [OUT_WIDTH-1:0]   m_delta_reg;
    logic signed [OUT_WIDTH-1:0]   m_position_reg;
    logic signed [OUT_WIDTH-1:0]   m_delta_next;
    logic signed [OUT_WIDTH-1:0]   m_position_next;

    logic                   advance;
    logic                   wheel_ok;
    logic [WIDX-1:0]        wheel_idx;
    logic                   cur_a;
    logic                   cur_b;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] cur_last;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] last_next;
    logic signed [OUT_WIDTH-1:0] step_delta;
    logic signed [OUT_WIDTH-1:0] step_position;
    step_ctl_t              ctl;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign wheel_idx = WIDX'(in_wheel_reg);
    assign wheel_ok  = (32'(in_wheel_reg) < WHEELS);

    always_comb begin
        cur_a     = 1'b0;
        cur_b     = 1'b0;
        cur_count = '0;
        cur_last  = '0;
        for (int i = 0; i < WHEELS; i++) begin
            if (WIDX'(i) == wheel_idx) begin
                cur_a     = prev_a_reg[i];
                cur_b     = prev_b_reg[i];
                cur_count = count_reg[i];
                cur_last  = last_reg[i];
            end
        end
    end

    dqd_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .cmd        (in_cmd_reg),
        .phase_a    (in_a_reg),
        .phase_b    (in_b_reg),
        .prev_a     (cur_a),
        .prev_b     (cur_b),
        .count      (cur_count),
        .last       (cur_last),
        .count_next (count_next),
        .last_next  (last_next),
        .delta      (step_delta),
        .position   (step_position),
        .ctl        (ctl)
    );

    assign m_delta_next    = wheel_ok ? step_delta : '0;
    assign m_position_next = wheel_ok ? step_position : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg   <= s_command;
            in_wheel_reg <= s_wheel;
            in_a_reg     <= s_phase_a;
            in_b_reg     <= s_phase_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_a_reg <= '0;
            prev_b_reg <= '0;
            for (int i = 0; i < WHEELS; i++) begin
                count_reg[i] <= '0;
                last_reg[i]  <= '0;
            end
        end else if (advance && wheel_ok) begin
            for (int i = 0; i < WHEELS; i++) begin
                if (WIDX'(i) == wheel_idx) begin
                    if (ctl.load_phase) begin
                        prev_a_reg[i] <= in_a_reg;
                        prev_b_reg[i] <= in_b_reg;
                    end
                    if (ctl.load_count) begin
                        count_reg[i] <= count_next;
                    end
                    if (ctl.load_last) begin
                        last_reg[i] <= last_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_delta_reg    <= m_delta_next;
            m_position_reg <= m_position_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_delta    = m_delta_reg;
    assign m_position = m_position_reg;

`ifndef SYNTHESIS
    a_delta_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_cmd_reg != CMD_READ) |=> (m_delta == '0))
        else $error("nonzero delta on a non-read item");

    a_seed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_cmd_reg == CMD_SEED) |=> (m_position == '0))
        else $error("seed item returned nonzero position");

    a_rebase_last: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && wheel_ok && (in_cmd_reg == CMD_REBASE)
        |=> (last_reg[$past(wheel_idx)] == count_reg[$past(wheel_idx)]))
        else $error("rebase did not align read point with count");

    a_sample_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && wheel_ok && (in_cmd_reg == CMD_SAMPLE)
        |=> (prev_a_reg[$past(wheel_idx)] == $past(in_a_reg))
            && (prev_b_reg[$past(wheel_idx)] == $past(in_b_reg)))
        else $error("sample did not store phase levels");
`endif

endmodule

`default_nettype wire

// File: tb/dual_quadrature_decoder_test.sv
// Self-checking testbench for dual_quadrature_decoder: directed, gray-code walk and noise items
// with random sender bursts and receiver stalls, checked against an in-bench decoder.
// Depends on dqd_pkg and the dual_quadrature_decoder RTL.
`timescale 1ns / 100ps

module dual_quadrature_decoder_test;
    import dqd_pkg::*;

    typedef struct {
        logic signed [OUT_WIDTH-1:0] delta;
        logic signed [OUT_WIDTH-1:0] position;
    } readout_t;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    cmd_t                        s_command = CMD_SAMPLE;
    logic                        s_wheel = 1'b0;
    logic                        s_phase_a = 1'b0;
    logic                        s_phase_b = 1'b0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [OUT_WIDTH-1:0] m_delta;
    logic signed [OUT_WIDTH-1:0] m_position;

    logic [31:0] wheel_count [2];
    logic [31:0] wheel_mark  [2];
    logic        wheel_a     [2];
    logic        wheel_b     [2];

    readout_t owed_readouts[$];
    readout_t arrived;
    int       fail_count = 0;
    int       burst_left = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_tick = 0;

    dual_quadrature_decoder #(
        .WHEELS     (2),
        .COUNT_WIDTH(32)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_wheel   (s_wheel),
        .s_phase_a (s_phase_a),
        .s_phase_b (s_phase_b),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_delta   (m_delta),
        .m_position(m_position)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic readout_t decode_step(cmd_t cmd, logic w, logic a, logic b);
        readout_t r;
        r.delta = '0;
        case (cmd)
            CMD_SAMPLE: begin
                if (a != wheel_a[w]) begin
                    wheel_count[w] = (a == b) ? wheel_count[w] + 1 : wheel_count[w] - 1;
                end else if (b != wheel_b[w]) begin
                    wheel_count[w] = (a == b) ? wheel_count[w] - 1 : wheel_count[w] + 1;
                end
                wheel_a[w] = a;
                wheel_b[w] = b;
            end
            CMD_READ: begin
                r.delta = wheel_count[w] - wheel_mark[w];
                wheel_mark[w] = wheel_count[w];
            end
            CMD_REBASE: begin
                wheel_mark[w] = wheel_count[w];
            end
            default: begin
                wheel_a[w] = a;
                wheel_b[w] = b;
                wheel_count[w] = '0;
                wheel_mark[w] = '0;
            end
        endcase
        r.position = wheel_count[w];
        return r;
    endfunction

    task automatic send_item(cmd_t cmd, logic w, logic a, logic b);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = $urandom_range(0, 7);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_command = cmd;
        s_wheel = w;
        s_phase_a = a;
        s_phase_b = b;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        owed_readouts.push_back(decode_step(cmd, w, a, b));
    endtask

    task automatic wait_drained(int limit);
        int n;
        n = 0;
        @(negedge aclk);
        s_valid = 1'b0;
        burst_left = 0;
        while (owed_readouts.size() != 0 && n < limit) begin
            @(posedge aclk);
            n++;
        end
        repeat (8) @(posedge aclk);
        if (owed_readouts.size() != 0) begin
            $error("%0d results never arrived", owed_readouts.size());
            fail_count++;
        end
    endtask

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:     m_ready <= 1'b1;
            RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
            default:     m_ready <= (rx_tick % 3 != 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (owed_readouts.size() == 0) begin
                $error("result with none pending: delta %0d position %0d", m_delta, m_position);
                fail_count++;
            end else begin
                arrived = owed_readouts.pop_front();
                if (m_delta !== arrived.delta) begin
                    $error("delta: expected %0d, actual %0d", arrived.delta, m_delta);
                    fail_count++;
                end
                if (m_position !== arrived.position) begin
                    $error("position: expected %0d, actual %0d", arrived.position, m_position);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed();
        send_item(CMD_SEED,   1'b0, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 1'b0, 1'b0, 1'b1);
        send_item(CMD_SAMPLE, 1'b0, 1'b1, 1'b1);
        send_item(CMD_SAMPLE, 1'b0, 1'b1, 1'b0);
        send_item(CMD_SAMPLE, 1'b0, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 1'b0, 1'b0, 1'b0);
        send_item(CMD_READ,   1'b0, 1'b1, 1'b1);
        send_item(CMD_SAMPLE, 1'b0, 1'b1, 1'b0);
        send_item(CMD_SAMPLE, 1'b0, 1'b1, 1'b1);
        send_item(CMD_SAMPLE, 1'b0, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 1'b0, 1'b1, 1'b1);
        send_item(CMD_REBASE, 1'b0, 1'b1, 1'b0);
        send_item(CMD_SAMPLE, 1'b0, 1'b0, 1'b1);
        send_item(CMD_READ,   1'b0, 1'b0, 1'b1);
        send_item(CMD_SEED,   1'b1, 1'b0, 1'b0);
        send_item(CMD_SAMPLE, 1'b1, 1'b1, 1'b0);
        send_item(CMD_SAMPLE, 1'b1, 1'b1, 1'b1);
        send_item(CMD_READ,   1'b1, 1'b0, 1'b0);
        send_item(CMD_SEED,   1'b1, 1'b1, 1'b1);
        send_item(CMD_SAMPLE, 1'b1, 1'b0, 1'b1);
        send_item(CMD_REBASE, 1'b1, 1'b0, 1'b0);
        send_item(CMD_READ,   1'b1, 1'b1, 1'b1);
        send_item(CMD_SEED,   1'b0, 1'b1, 1'b0);
        send_item(CMD_READ,   1'b0, 1'b0, 1'b0);
    endtask

    // Walk each wheel around the gray-code circle, with reversals, stalls,
    // skipped states, reads, rebases, reseeds and a little noise.
    task automatic test_phase_walk(int items);
        logic lvl_a [2];
        logic lvl_b [2];
        logic fwd   [2];
        logic w;
        int   pick;
        for (int i = 0; i < 2; i++) begin
            lvl_a[i] = 1'($urandom_range(0, 1));
            lvl_b[i] = 1'($urandom_range(0, 1));
            fwd[i] = 1'($urandom_range(0, 1));
            send_item(CMD_SEED, i[0], lvl_a[i], lvl_b[i]);
        end
        for (int n = 0; n < items; n++) begin
            w = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                if ($urandom_range(0, 11) == 0) fwd[w] = !fwd[w];
                if ((lvl_a[w] == lvl_b[w]) == fwd[w]) lvl_b[w] = !lvl_b[w];
                else lvl_a[w] = !lvl_a[w];
                send_item(CMD_SAMPLE, w, lvl_a[w], lvl_b[w]);
            end else if (pick < 68) begin
                send_item(CMD_SAMPLE, w, lvl_a[w], lvl_b[w]);
            end else if (pick < 74) begin
                lvl_a[w] = !lvl_a[w];
                lvl_b[w] = !lvl_b[w];
                send_item(CMD_SAMPLE, w, lvl_a[w], lvl_b[w]);
            end else if (pick < 87) begin
                send_item(CMD_READ, w, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (pick < 92) begin
                send_item(CMD_REBASE, w, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (pick < 95) begin
                lvl_a[w] = 1'($urandom_range(0, 1));
                lvl_b[w] = 1'($urandom_range(0, 1));
                send_item(CMD_SEED, w, lvl_a[w], lvl_b[w]);
            end else begin
                lvl_a[w] = 1'($urandom_range(0, 1));
                lvl_b[w] = 1'($urandom_range(0, 1));
                send_item(CMD_SAMPLE, w, lvl_a[w], lvl_b[w]);
            end
        end
    endtask

    task automatic test_noise(int items);
        for (int n = 0; n < items; n++) begin
            send_item(cmd_t'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_drain_pause();
        wait_drained(100000);
        test_phase_walk(40);
    endtask

    initial begin
        for (int i = 0; i < 2; i++) begin
            wheel_count[i] = '0;
            wheel_mark[i] = '0;
            wheel_a[i] = 1'b0;
            wheel_b[i] = 1'b0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_phase_walk(700);
        test_drain_pause();
        test_noise(450);
        test_phase_walk(640);

        wait_drained(100000);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
